// File: hw/rtl/rv64im_execute_unit_macros.svh
// ----------------------------------------------------------------------------
// rv64im_execute_unit assertion macros
// Shared property wrappers for the execute unit checker.
// ----------------------------------------------------------------------------
`ifndef RV64IM_EXECUTE_UNIT_MACROS_SVH
`define RV64IM_EXECUTE_UNIT_MACROS_SVH

// same-cycle implication, sampled on clk, off while in reset
`define RV64EX_ASSERT_IMP(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off while in reset
`define RV64EX_ASSERT_NXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// File: hw/rtl/rv64ex_pkg.sv
// ----------------------------------------------------------------------------
// rv64ex_pkg
// Operation codes, result struct and helpers shared by the execute unit.
// ----------------------------------------------------------------------------
`default_nettype none

package rv64ex_pkg;

	localparam int unsigned XLEN   = 64;
	localparam int unsigned NREGS  = 32;

	// operation codes, in decode order
	typedef enum logic [5:0] {
		CMD_ADD, CMD_ADDW, CMD_SUB, CMD_SUBW, CMD_XOR, CMD_OR, CMD_AND, CMD_SLL,
		CMD_SLLW, CMD_SLT, CMD_SLTU, CMD_SRL, CMD_SRLW, CMD_SRA, CMD_SRAW,
		CMD_ADDI, CMD_ADDIW, CMD_XORI, CMD_ORI, CMD_ANDI, CMD_SLLI,
		CMD_SLLIW, CMD_SRLI, CMD_SRLIW, CMD_SRAI, CMD_SRAIW, CMD_SLTI,
		CMD_SLTIU, CMD_BEQ, CMD_BNE, CMD_BLT, CMD_BGE, CMD_BLTU, CMD_BGEU,
		CMD_JAL, CMD_JALR, CMD_LUI, CMD_AUIPC, CMD_MUL, CMD_MULH,
		CMD_MULHSU, CMD_MULHU, CMD_MULW, CMD_DIV, CMD_DIVU, CMD_DIVW,
		CMD_DIVUW, CMD_REM, CMD_REMU, CMD_REMW, CMD_REMUW, CMD_FENCE,
		CMD_FENCE_I, CMD_SFENCE_VMA, CMD_EBREAK
	} cmd_e;

	// combinational datapath outcome
	typedef struct packed {
		logic [XLEN-1:0] value;
		logic            wr;
		logic [XLEN-1:0] npc;
		logic            ill;
		logic            brk;
		logic            mdu;
	} alu_res_t;

	function automatic logic [XLEN-1:0] sext32(input logic [XLEN-1:0] v);
		sext32 = {{32{v[31]}}, v[31:0]};
	endfunction

endpackage

`default_nettype wire

// File: hw/rtl/rv64ex_ram.sv
// ----------------------------------------------------------------------------
// rv64ex_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64ex_ram #(
	parameter int unsigned WIDTH = 64,
	parameter int unsigned DEPTH = 32
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output      logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rv64ex_alu.sv
// ----------------------------------------------------------------------------
// rv64ex_alu
// Combinational integer datapath: ALU, shifts, compares, branches and jumps.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64ex_alu (
	input  wire logic [5:0]                  cmd,
	input  wire logic [rv64ex_pkg::XLEN-1:0] a,
	input  wire logic [rv64ex_pkg::XLEN-1:0] b,
	input  wire logic [rv64ex_pkg::XLEN-1:0] imm,
	input  wire logic [rv64ex_pkg::XLEN-1:0] pc,
	output      rv64ex_pkg::alu_res_t        res
);

	logic [rv64ex_pkg::XLEN-1:0] pc4;
	logic [rv64ex_pkg::XLEN-1:0] pc_imm;
	logic [rv64ex_pkg::XLEN-1:0] a_w;
	logic                        take;

	assign pc4    = pc + 64'd4;
	assign pc_imm = pc + imm;
	assign a_w    = rv64ex_pkg::sext32(a);

	// operation decode and evaluation
	always_comb begin
		res       = '0;
		res.wr    = 1'b1;
		res.npc   = pc4;
		take      = 1'b0;
		case (rv64ex_pkg::cmd_e'(cmd))
			rv64ex_pkg::CMD_ADD:   res.value = a + b;
			rv64ex_pkg::CMD_ADDW:  res.value = rv64ex_pkg::sext32(a + b);
			rv64ex_pkg::CMD_SUB:   res.value = a - b;
			rv64ex_pkg::CMD_SUBW:  res.value = rv64ex_pkg::sext32(a - b);
			rv64ex_pkg::CMD_XOR:   res.value = a ^ b;
			rv64ex_pkg::CMD_OR:    res.value = a | b;
			rv64ex_pkg::CMD_AND:   res.value = a & b;
			rv64ex_pkg::CMD_SLL:   res.value = a << b[5:0];
			rv64ex_pkg::CMD_SLLW:  res.value = rv64ex_pkg::sext32(a << b[4:0]);
			rv64ex_pkg::CMD_SLT:   res.value = {63'd0, $signed(a) < $signed(b)};
			rv64ex_pkg::CMD_SLTU:  res.value = {63'd0, a < b};
			rv64ex_pkg::CMD_SRL:   res.value = a >> b[5:0];
			rv64ex_pkg::CMD_SRLW:
				res.value = rv64ex_pkg::sext32({32'd0, a[31:0]} >> b[4:0]);
			rv64ex_pkg::CMD_SRA:   res.value = $unsigned($signed(a) >>> b[5:0]);
			rv64ex_pkg::CMD_SRAW:
				res.value = rv64ex_pkg::sext32($unsigned($signed(a_w) >>> b[4:0]));
			rv64ex_pkg::CMD_ADDI:  res.value = a + imm;
			rv64ex_pkg::CMD_ADDIW: res.value = rv64ex_pkg::sext32(a + imm);
			rv64ex_pkg::CMD_XORI:  res.value = a ^ imm;
			rv64ex_pkg::CMD_ORI:   res.value = a | imm;
			rv64ex_pkg::CMD_ANDI:  res.value = a & imm;
			rv64ex_pkg::CMD_SLLI:  res.value = a << imm[5:0];
			rv64ex_pkg::CMD_SLLIW: res.value = rv64ex_pkg::sext32(a << imm[4:0]);
			rv64ex_pkg::CMD_SRLI:  res.value = a >> imm[5:0];
			rv64ex_pkg::CMD_SRLIW:
				res.value = rv64ex_pkg::sext32({32'd0, a[31:0]} >> imm[4:0]);
			rv64ex_pkg::CMD_SRAI:  res.value = $unsigned($signed(a) >>> imm[5:0]);
			rv64ex_pkg::CMD_SRAIW:
				res.value = rv64ex_pkg::sext32($unsigned($signed(a_w) >>> imm[4:0]));
			rv64ex_pkg::CMD_SLTI:  res.value = {63'd0, $signed(a) < $signed(imm)};
			rv64ex_pkg::CMD_SLTIU: res.value = {63'd0, a < imm};
			rv64ex_pkg::CMD_BEQ: begin
				res.wr = 1'b0;
				take   = (a == b);
			end
			rv64ex_pkg::CMD_BNE: begin
				res.wr = 1'b0;
				take   = (a != b);
			end
			rv64ex_pkg::CMD_BLT: begin
				res.wr = 1'b0;
				take   = $signed(a) < $signed(b);
			end
			rv64ex_pkg::CMD_BGE: begin
				res.wr = 1'b0;
				take   = !($signed(a) < $signed(b));
			end
			rv64ex_pkg::CMD_BLTU: begin
				res.wr = 1'b0;
				take   = (a < b);
			end
			rv64ex_pkg::CMD_BGEU: begin
				res.wr = 1'b0;
				take   = (a >= b);
			end
			rv64ex_pkg::CMD_JAL: begin
				res.value = pc4;
				res.npc   = pc_imm;
			end
			rv64ex_pkg::CMD_JALR: begin
				res.value = pc4;
				res.npc   = (a + imm) & ~64'd1;
			end
			rv64ex_pkg::CMD_LUI:   res.value = imm;
			rv64ex_pkg::CMD_AUIPC: res.value = pc_imm;
			rv64ex_pkg::CMD_FENCE, rv64ex_pkg::CMD_FENCE_I,
			rv64ex_pkg::CMD_SFENCE_VMA: res.wr = 1'b0;
			rv64ex_pkg::CMD_EBREAK: begin
				res.wr  = 1'b0;
				res.brk = 1'b1;
			end
			default: begin
				// multiply/divide go to the iterative unit; anything else is illegal
				if (cmd inside {[rv64ex_pkg::CMD_MUL:rv64ex_pkg::CMD_REMUW]}) begin
					res.mdu = 1'b1;
				end else begin
					res.wr  = 1'b0;
					res.ill = 1'b1;
				end
			end
		endcase
		if (take) begin
			res.npc = pc_imm;
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rv64ex_mdu.sv
// ----------------------------------------------------------------------------
// rv64ex_mdu
// Iterative multiply/divide: one bit per cycle shift-add and restoring divide.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64ex_mdu (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [5:0]                  cmd,
	input  wire logic [rv64ex_pkg::XLEN-1:0] a,
	input  wire logic [rv64ex_pkg::XLEN-1:0] b,
	output      logic                        done,
	output      logic [rv64ex_pkg::XLEN-1:0] result
);

	typedef enum logic [2:0] {M_IDLE, M_MUL, M_FIX1, M_FIX2, M_DIV, M_SIGN} mstate_t;

	mstate_t          state_q;
	rv64ex_pkg::cmd_e op_q;
	logic [5:0]       cnt_q;
	logic [63:0]      hi_q;      // product high half / partial remainder
	logic [63:0]      lo_q;      // multiplier / dividend, shifted out
	logic [63:0]      opa_q;     // raw a (mulh fix) or extended dividend
	logic [63:0]      opb_q;     // multiplicand / divisor magnitude
	logic             bneg_q;    // raw b sign for mulh fix
	logic             qneg_q;
	logic             rneg_q;
	logic             dz_q;

	rv64ex_pkg::cmd_e op_in;
	logic             is_mul;
	logic             word_in;
	logic             sgn_in;
	logic [63:0]      x_ext;
	logic [63:0]      y_ext;
	logic [64:0]      mul_sum;
	logic [64:0]      div_trial;
	logic [63:0]      fix_hi;
	logic [63:0]      mul_sel;
	logic [63:0]      div_q;
	logic [63:0]      div_r;
	logic [63:0]      div_sel;
	logic             is_rem;
	logic             word_op;

	assign op_in   = rv64ex_pkg::cmd_e'(cmd);
	assign is_mul  = cmd inside {[rv64ex_pkg::CMD_MUL:rv64ex_pkg::CMD_MULW]};
	assign word_in = (op_in == rv64ex_pkg::CMD_DIVW) || (op_in == rv64ex_pkg::CMD_DIVUW)
		|| (op_in == rv64ex_pkg::CMD_REMW) || (op_in == rv64ex_pkg::CMD_REMUW);
	assign sgn_in  = (op_in == rv64ex_pkg::CMD_DIV) || (op_in == rv64ex_pkg::CMD_DIVW)
		|| (op_in == rv64ex_pkg::CMD_REM) || (op_in == rv64ex_pkg::CMD_REMW);

	// operand extension for the word forms
	always_comb begin
		if (!word_in) begin
			x_ext = a;
			y_ext = b;
		end else if (sgn_in) begin
			x_ext = rv64ex_pkg::sext32(a);
			y_ext = rv64ex_pkg::sext32(b);
		end else begin
			x_ext = {32'd0, a[31:0]};
			y_ext = {32'd0, b[31:0]};
		end
	end

	assign mul_sum   = {1'b0, hi_q} + (lo_q[0] ? {1'b0, opb_q} : 65'd0);
	assign div_trial = {hi_q, lo_q[63]} - {1'b0, opb_q};

	// high-half sign correction, second term, and result pick
	always_comb begin
		fix_hi = hi_q - ((op_q == rv64ex_pkg::CMD_MULH && bneg_q) ? opa_q : 64'd0);
		case (op_q)
			rv64ex_pkg::CMD_MUL:  mul_sel = lo_q;
			rv64ex_pkg::CMD_MULW: mul_sel = rv64ex_pkg::sext32(lo_q);
			default:              mul_sel = fix_hi;
		endcase
	end

	assign is_rem  = op_q inside {[rv64ex_pkg::CMD_REM:rv64ex_pkg::CMD_REMUW]};
	assign word_op = (op_q == rv64ex_pkg::CMD_DIVW) || (op_q == rv64ex_pkg::CMD_DIVUW)
		|| (op_q == rv64ex_pkg::CMD_REMW) || (op_q == rv64ex_pkg::CMD_REMUW);

	// sign restore, divide-by-zero override, word narrowing
	always_comb begin
		div_q = qneg_q ? (~lo_q + 64'd1) : lo_q;
		div_r = rneg_q ? (~hi_q + 64'd1) : hi_q;
		if (dz_q) begin
			div_sel = is_rem ? opa_q : '1;
		end else begin
			div_sel = is_rem ? div_r : div_q;
		end
		if (word_op) begin
			div_sel = rv64ex_pkg::sext32(div_sel);
		end
	end

	// sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= M_IDLE;
			done    <= 1'b0;
		end else begin
			done <= (state_q == M_FIX2) || (state_q == M_SIGN);
			case (state_q)
				M_IDLE: begin
					if (start) begin
						op_q  <= op_in;
						cnt_q <= '0;
						hi_q  <= '0;
						if (is_mul) begin
							lo_q    <= a;
							opa_q   <= a;
							opb_q   <= b;
							bneg_q  <= b[63];
							state_q <= M_MUL;
						end else begin
							lo_q    <= (sgn_in && x_ext[63]) ? (~x_ext + 64'd1) : x_ext;
							opb_q   <= (sgn_in && y_ext[63]) ? (~y_ext + 64'd1) : y_ext;
							opa_q   <= x_ext;
							qneg_q  <= sgn_in && (x_ext[63] ^ y_ext[63]);
							rneg_q  <= sgn_in && x_ext[63];
							dz_q    <= (y_ext == 64'd0);
							state_q <= M_DIV;
						end
					end
				end
				M_MUL: begin
					hi_q  <= mul_sum[64:1];
					lo_q  <= {mul_sum[0], lo_q[63:1]};
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= M_FIX1;
					end
				end
				M_FIX1: begin
					// first signed correction: a negative takes b off
					if ((op_q == rv64ex_pkg::CMD_MULH || op_q == rv64ex_pkg::CMD_MULHSU)
						&& opa_q[63]) begin
						hi_q <= hi_q - opb_q;
					end
					state_q <= M_FIX2;
				end
				M_FIX2: begin
					result  <= mul_sel;
					state_q <= M_IDLE;
				end
				M_DIV: begin
					if (!div_trial[64]) begin
						hi_q <= div_trial[63:0];
						lo_q <= {lo_q[62:0], 1'b1};
					end else begin
						hi_q <= {hi_q[62:0], lo_q[63]};
						lo_q <= {lo_q[62:0], 1'b0};
					end
					cnt_q <= cnt_q + 6'd1;
					if (cnt_q == 6'd63) begin
						state_q <= M_SIGN;
					end
				end
				M_SIGN: begin
					result  <= div_sel;
					state_q <= M_IDLE;
				end
				default: state_q <= M_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rv64im_execute_unit.sv
// ----------------------------------------------------------------------------
// rv64im_execute_unit
// RV64IM integer execute stage with a RAM-based register file.
// ----------------------------------------------------------------------------
//  channel | direction | handshake           | beat contents
//  in      | input     | in_valid/in_ready   | cmd, register indexes, immediate, pc
//  out     | output    | out_valid/out_ready | write value/enable, next pc, flags
//
//  One instruction in flight. ALU ops pass from the accept through execute
//  and output load to the result register; mul and div/rem ops go from
//  execute through the one-bit-per-cycle multiply/divide unit to output load.
//  A new instruction is accepted only after the previous result is loaded.
//  Reset clears all registers to zero at once through per-entry valid bits.
//  A result held by out_ready low stalls the next result, not the next accept.
// ----------------------------------------------------------------------------
`default_nettype none

module rv64im_execute_unit (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output      logic        in_ready,
	input  wire logic [5:0]  cmd,
	input  wire logic [4:0]  dest_index,
	input  wire logic [4:0]  src1_index,
	input  wire logic [4:0]  src2_index,
	input  wire logic [31:0] immediate,
	input  wire logic [63:0] current_pc,
	output      logic        out_valid,
	input  wire logic        out_ready,
	output      logic [63:0] write_value,
	output      logic        write_enable,
	output      logic [63:0] next_pc,
	output      logic        illegal,
	output      logic        halted
);

	typedef enum logic [1:0] {S_IDLE, S_EXEC, S_MDU, S_OUT} state_t;

	state_t                        state_q;
	logic [5:0]                    cmd_s1;
	logic [4:0]                    rd_s1;
	logic [63:0]                   imm_s1;
	logic [63:0]                   pc_s1;
	logic                          v1_s1;
	logic                          v2_s1;
	logic [rv64ex_pkg::NREGS-1:0]  vld_q;
	logic                          halt_q;
	logic [63:0]                   val_q;
	logic                          wr_q;
	logic [63:0]                   npc_q;
	logic                          ill_q;

	logic                          accept;
	logic [63:0]                   rdata1;
	logic [63:0]                   rdata2;
	logic [63:0]                   op_a;
	logic [63:0]                   op_b;
	rv64ex_pkg::alu_res_t          alu_res;
	logic                          rd_nz;
	logic                          mdu_start;
	logic                          mdu_done;
	logic [63:0]                   mdu_result;
	logic                          rf_we;
	logic [63:0]                   rf_wdata;

	assign in_ready  = (state_q == S_IDLE);
	assign accept    = in_valid && in_ready;
	assign rd_nz     = (rd_s1 != 5'd0);
	assign op_a      = v1_s1 ? rdata1 : 64'd0;
	assign op_b      = v2_s1 ? rdata2 : 64'd0;
	assign mdu_start = (state_q == S_EXEC) && alu_res.mdu;

	// write-back to the register file, x0 never written
	always_comb begin
		rf_we    = 1'b0;
		rf_wdata = alu_res.value;
		if (state_q == S_EXEC && !alu_res.mdu && alu_res.wr && rd_nz) begin
			rf_we = 1'b1;
		end else if (state_q == S_MDU && mdu_done && rd_nz) begin
			rf_we    = 1'b1;
			rf_wdata = mdu_result;
		end
	end

	// two copies of the register file, one per source operand
	rv64ex_ram #(.WIDTH(64), .DEPTH(rv64ex_pkg::NREGS)) u_rf_a (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd_s1),
		.wdata (rf_wdata),
		.re    (accept),
		.raddr (src1_index),
		.rdata (rdata1)
	);

	rv64ex_ram #(.WIDTH(64), .DEPTH(rv64ex_pkg::NREGS)) u_rf_b (
		.clk   (clk),
		.we    (rf_we),
		.waddr (rd_s1),
		.wdata (rf_wdata),
		.re    (accept),
		.raddr (src2_index),
		.rdata (rdata2)
	);

	rv64ex_alu u_alu (
		.cmd (cmd_s1),
		.a   (op_a),
		.b   (op_b),
		.imm (imm_s1),
		.pc  (pc_s1),
		.res (alu_res)
	);

	rv64ex_mdu u_mdu (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (mdu_start),
		.cmd    (cmd_s1),
		.a      (op_a),
		.b      (op_b),
		.done   (mdu_done),
		.result (mdu_result)
	);

	// instruction capture (payload, no reset)
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_s1 <= cmd;
			rd_s1  <= dest_index;
			imm_s1 <= {{32{immediate[31]}}, immediate};
			pc_s1  <= current_pc;
		end
	end

	// valid bits: an entry never written reads as zero
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
			v1_s1 <= 1'b0;
			v2_s1 <= 1'b0;
		end else begin
			if (accept) begin
				v1_s1 <= vld_q[src1_index];
				v2_s1 <= vld_q[src2_index];
			end
			if (rf_we) begin
				vld_q[rd_s1] <= 1'b1;
			end
		end
	end

	// sequencer, result holding and output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			halt_q       <= 1'b0;
			out_valid    <= 1'b0;
			write_value  <= '0;
			write_enable <= 1'b0;
			next_pc      <= '0;
			illegal      <= 1'b0;
			halted       <= 1'b0;
			val_q        <= '0;
			wr_q         <= 1'b0;
			npc_q        <= '0;
			ill_q        <= 1'b0;
		end else begin
			// beat taken and nothing new loaded this cycle
			if (out_valid && out_ready && state_q != S_OUT) begin
				out_valid <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_EXEC;
					end
				end
				S_EXEC: begin
					npc_q <= alu_res.npc;
					ill_q <= alu_res.ill;
					if (alu_res.brk) begin
						halt_q <= 1'b1;
					end
					if (alu_res.mdu) begin
						state_q <= S_MDU;
					end else begin
						wr_q    <= alu_res.wr && rd_nz;
						val_q   <= (alu_res.wr && rd_nz) ? alu_res.value : 64'd0;
						state_q <= S_OUT;
					end
				end
				S_MDU: begin
					if (mdu_done) begin
						wr_q    <= rd_nz;
						val_q   <= rd_nz ? mdu_result : 64'd0;
						state_q <= S_OUT;
					end
				end
				S_OUT: begin
					if (!out_valid || out_ready) begin
						out_valid    <= 1'b1;
						write_value  <= val_q;
						write_enable <= wr_q;
						next_pc      <= npc_q;
						illegal      <= ill_q;
						halted       <= halt_q;
						state_q      <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

endmodule

`default_nettype wire

// File: hw/rtl/rv64ex_checker.sv
// ----------------------------------------------------------------------------
// rv64ex_checker
// Port-level checks on the execute unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none

`include "rv64im_execute_unit_macros.svh"

module rv64ex_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [63:0] write_value,
	input wire logic        write_enable,
	input wire logic        illegal,
	input wire logic        halted
);

	// a stalled result beat keeps its value
	`RV64EX_ASSERT_NXT(a_out_hold, out_valid && !out_ready, out_valid && $stable(write_value), "result beat changed while stalled")

	// no write means a zero value
	`RV64EX_ASSERT_IMP(a_zero_nowr, out_valid && !write_enable, write_value == 64'd0, "non-zero value without write")

	// an illegal op never writes
	`RV64EX_ASSERT_IMP(a_ill_nowr, out_valid && illegal, !write_enable, "illegal op wrote a register")

	// halt is sticky until reset
	`RV64EX_ASSERT_NXT(a_halt_sticky, halted, halted, "halt flag dropped")

endmodule

bind rv64im_execute_unit rv64ex_checker u_rv64ex_checker (
	.clk          (clk),
	.arst_n       (arst_n),
	.out_valid    (out_valid),
	.out_ready    (out_ready),
	.write_value  (write_value),
	.write_enable (write_enable),
	.illegal      (illegal),
	.halted       (halted)
);

`default_nettype wire
